// File: sv/rycc_pkg.sv
// ----------------------------------------------------------------------------
// rycc_pkg: shared types and constants for the RGB block to YCbCr 4:2:0 core
// Holds the weight register layout, register indexes, scale and bias values.
// ----------------------------------------------------------------------------
`default_nettype none

package rycc_pkg;

    localparam int PIX_W  = 8;
    localparam int WGT_W  = 16;
    localparam int REG_W  = 3 * WGT_W;
    localparam int IDX_W  = 2;
    localparam int NPIX   = 4;

    localparam int PIPE_DEPTH = 5;

    typedef enum logic [IDX_W-1:0] {
        REG_LUMA = 2'd0,
        REG_CB   = 2'd1,
        REG_CR   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [WGT_W-1:0] red;
        logic signed [WGT_W-1:0] green;
        logic signed [WGT_W-1:0] blue;
    } weights_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    localparam logic signed [16:0] LUMA_SCALE   = 17'sd56285;
    localparam logic signed [16:0] CHROMA_SCALE = 17'sd57570;

    localparam int LUMA_SHIFT   = 30;
    localparam int CHROMA_SHIFT = 32;

    localparam logic signed [43:0] LUMA_BIAS   = 44'sd17716740096;
    localparam logic signed [45:0] CHROMA_BIAS = 46'sd551903297536;

endpackage

`default_nettype wire

// File: sv/rycc_ifs.sv
// ----------------------------------------------------------------------------
// rycc_ifs: request channels of the RGB block to YCbCr 4:2:0 core
// Pixel block input, YCbCr result output and weight register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rycc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] lower_left_red;
    logic [7:0] lower_left_green;
    logic [7:0] lower_left_blue;
    logic [7:0] lower_right_red;
    logic [7:0] lower_right_green;
    logic [7:0] lower_right_blue;
    logic [7:0] upper_left_red;
    logic [7:0] upper_left_green;
    logic [7:0] upper_left_blue;
    logic [7:0] upper_right_red;
    logic [7:0] upper_right_green;
    logic [7:0] upper_right_blue;

    modport source (
        output valid,
        output lower_left_red, lower_left_green, lower_left_blue,
        output lower_right_red, lower_right_green, lower_right_blue,
        output upper_left_red, upper_left_green, upper_left_blue,
        output upper_right_red, upper_right_green, upper_right_blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  lower_left_red, lower_left_green, lower_left_blue,
        input  lower_right_red, lower_right_green, lower_right_blue,
        input  upper_left_red, upper_left_green, upper_left_blue,
        input  upper_right_red, upper_right_green, upper_right_blue,
        output ready
    );
endinterface

interface rycc_ycc_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_lower_left;
    logic [7:0] luma_lower_right;
    logic [7:0] luma_upper_left;
    logic [7:0] luma_upper_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;

    modport source (
        output valid,
        output luma_lower_left, luma_lower_right, luma_upper_left, luma_upper_right,
        output chroma_blue, chroma_red,
        input  ready
    );

    modport sink (
        input  valid,
        input  luma_lower_left, luma_lower_right, luma_upper_left, luma_upper_right,
        input  chroma_blue, chroma_red,
        output ready
    );
endinterface

interface rycc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;

    modport source (
        output valid,
        output index,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  index,
        input  data,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/rycc_luma_lane.sv
// ----------------------------------------------------------------------------
// rycc_luma_lane: five-stage luma pipeline for one pixel
// Weighted products, their sum, the studio scale, bias and round, then clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rycc_luma_lane (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire rycc_pkg::weights_t wgt,
    input  wire rycc_pkg::rgb_t    pix,
    output logic [7:0]             luma
);

    logic signed [24:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic signed [24:0] prod_r_next, prod_g_next, prod_b_next;
    logic signed [25:0] sum_reg, sum_next;
    logic signed [42:0] acc_reg, acc_next;
    logic signed [43:0] biased_reg, biased_next;
    logic [7:0]         luma_reg, luma_next;
    logic [13:0]        quot;

    always_comb
    begin
        prod_r_next = wgt.red   * $signed({1'b0, pix.red});
        prod_g_next = wgt.green * $signed({1'b0, pix.green});
        prod_b_next = wgt.blue  * $signed({1'b0, pix.blue});
        sum_next    = 26'(prod_r_reg) + 26'(prod_g_reg) + 26'(prod_b_reg);
        acc_next    = 43'(sum_reg) * 43'(rycc_pkg::LUMA_SCALE);
        biased_next = 44'(acc_reg) + rycc_pkg::LUMA_BIAS;
        quot        = biased_reg[43:rycc_pkg::LUMA_SHIFT];
        if (biased_reg < 0)
        begin
            luma_next = 8'd0;
        end
        else if (quot[13:8] != 6'd0)
        begin
            luma_next = 8'd255;
        end
        else
        begin
            luma_next = quot[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_r_reg <= prod_r_next;
            prod_g_reg <= prod_g_next;
            prod_b_reg <= prod_b_next;
            sum_reg    <= sum_next;
            acc_reg    <= acc_next;
            biased_reg <= biased_next;
            luma_reg   <= luma_next;
        end
    end

    assign luma = luma_reg;

endmodule

`default_nettype wire

// File: sv/rycc_chroma_path.sv
// ----------------------------------------------------------------------------
// rycc_chroma_path: five-stage Cb and Cr pipeline for one pixel block
// Block sums, weighted products, their sums, the studio scale, round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rycc_chroma_path (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire rycc_pkg::weights_t wgt_cb,
    input  wire rycc_pkg::weights_t wgt_cr,
    input  wire rycc_pkg::rgb_t     pix [rycc_pkg::NPIX],
    output logic [7:0]              chroma_blue,
    output logic [7:0]              chroma_red
);

    logic [9:0]         sum_r_reg, sum_g_reg, sum_b_reg;
    logic [9:0]         sum_r_next, sum_g_next, sum_b_next;
    logic signed [26:0] cb_r_reg, cb_g_reg, cb_b_reg, cr_r_reg, cr_g_reg, cr_b_reg;
    logic signed [26:0] cb_r_next, cb_g_next, cb_b_next, cr_r_next, cr_g_next, cr_b_next;
    logic signed [27:0] cb_sum_reg, cr_sum_reg, cb_sum_next, cr_sum_next;
    logic signed [44:0] cb_acc_reg, cr_acc_reg, cb_acc_next, cr_acc_next;
    logic signed [45:0] cb_v, cr_v;
    logic [13:0]        cb_q, cr_q;
    logic [7:0]         cb_reg, cr_reg, cb_next, cr_next;

    always_comb
    begin
        sum_r_next = 10'(pix[0].red) + 10'(pix[1].red) + 10'(pix[2].red) + 10'(pix[3].red);
        sum_g_next = 10'(pix[0].green) + 10'(pix[1].green)
                   + 10'(pix[2].green) + 10'(pix[3].green);
        sum_b_next = 10'(pix[0].blue) + 10'(pix[1].blue) + 10'(pix[2].blue) + 10'(pix[3].blue);

        cb_r_next = wgt_cb.red   * $signed({1'b0, sum_r_reg});
        cb_g_next = wgt_cb.green * $signed({1'b0, sum_g_reg});
        cb_b_next = wgt_cb.blue  * $signed({1'b0, sum_b_reg});
        cr_r_next = wgt_cr.red   * $signed({1'b0, sum_r_reg});
        cr_g_next = wgt_cr.green * $signed({1'b0, sum_g_reg});
        cr_b_next = wgt_cr.blue  * $signed({1'b0, sum_b_reg});

        cb_sum_next = 28'(cb_r_reg) + 28'(cb_g_reg) + 28'(cb_b_reg);
        cr_sum_next = 28'(cr_r_reg) + 28'(cr_g_reg) + 28'(cr_b_reg);

        cb_acc_next = 45'(cb_sum_reg) * 45'(rycc_pkg::CHROMA_SCALE);
        cr_acc_next = 45'(cr_sum_reg) * 45'(rycc_pkg::CHROMA_SCALE);

        cb_v = 46'(cb_acc_reg) + rycc_pkg::CHROMA_BIAS;
        cr_v = 46'(cr_acc_reg) + rycc_pkg::CHROMA_BIAS;
        cb_q = cb_v[45:rycc_pkg::CHROMA_SHIFT];
        cr_q = cr_v[45:rycc_pkg::CHROMA_SHIFT];

        if (cb_v < 0)
        begin
            cb_next = 8'd0;
        end
        else if (cb_q[13:8] != 6'd0)
        begin
            cb_next = 8'd255;
        end
        else
        begin
            cb_next = cb_q[7:0];
        end

        if (cr_v < 0)
        begin
            cr_next = 8'd0;
        end
        else if (cr_q[13:8] != 6'd0)
        begin
            cr_next = 8'd255;
        end
        else
        begin
            cr_next = cr_q[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_r_reg  <= sum_r_next;
            sum_g_reg  <= sum_g_next;
            sum_b_reg  <= sum_b_next;
            cb_r_reg   <= cb_r_next;
            cb_g_reg   <= cb_g_next;
            cb_b_reg   <= cb_b_next;
            cr_r_reg   <= cr_r_next;
            cr_g_reg   <= cr_g_next;
            cr_b_reg   <= cr_b_next;
            cb_sum_reg <= cb_sum_next;
            cr_sum_reg <= cr_sum_next;
            cb_acc_reg <= cb_acc_next;
            cr_acc_reg <= cr_acc_next;
            cb_reg     <= cb_next;
            cr_reg     <= cr_next;
        end
    end

    assign chroma_blue = cb_reg;
    assign chroma_red  = cr_reg;

endmodule

`default_nettype wire

// File: sv/rgb_block_to_ycbcr420.sv
// ----------------------------------------------------------------------------
// rgb_block_to_ycbcr420: 2x2 RGB block to studio-range YCbCr 4:2:0
// Four luma lanes and one chroma path share a five-stage stall-able pipeline.
// ----------------------------------------------------------------------------
// Throughput is one block per cycle; the pipeline stalls as a whole only
// while the output register holds a result that is not yet taken.
// Reset clears the stage valid bits and all three weight registers to zero.
// Weight writes are always accepted and take effect in the next cycle.
`default_nettype none

module rgb_block_to_ycbcr420 (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rycc_pix_if.sink    pixels,
    rycc_ycc_if.source  result,
    rycc_cfg_if.sink    cfg
);

    rycc_pkg::weights_t               luma_w_reg, cb_w_reg, cr_w_reg;
    logic [rycc_pkg::PIPE_DEPTH-1:0]  vld_reg, vld_next;
    logic                             advance;
    rycc_pkg::rgb_t                   pix [rycc_pkg::NPIX];
    logic [7:0]                       luma [rycc_pkg::NPIX];

    assign advance = !vld_reg[rycc_pkg::PIPE_DEPTH-1] || result.ready;
    assign pixels.ready = advance;
    assign cfg.ready = 1'b1;

    assign pix[0] = '{pixels.lower_left_red, pixels.lower_left_green, pixels.lower_left_blue};
    assign pix[1] = '{pixels.lower_right_red, pixels.lower_right_green,
                      pixels.lower_right_blue};
    assign pix[2] = '{pixels.upper_left_red, pixels.upper_left_green, pixels.upper_left_blue};
    assign pix[3] = '{pixels.upper_right_red, pixels.upper_right_green,
                      pixels.upper_right_blue};

    always_comb
    begin
        vld_next = {vld_reg[rycc_pkg::PIPE_DEPTH-2:0], pixels.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            luma_w_reg <= '0;
            cb_w_reg   <= '0;
            cr_w_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                vld_reg <= vld_next;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    rycc_pkg::REG_LUMA: luma_w_reg <= cfg.data;
                    rycc_pkg::REG_CB:   cb_w_reg   <= cfg.data;
                    rycc_pkg::REG_CR:   cr_w_reg   <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    for (genvar i = 0; i < rycc_pkg::NPIX; i++)
    begin : g_luma
        rycc_luma_lane u_lane (
            .clk  (clk),
            .en   (advance),
            .wgt  (luma_w_reg),
            .pix  (pix[i]),
            .luma (luma[i])
        );
    end

    rycc_chroma_path u_chroma (
        .clk         (clk),
        .en          (advance),
        .wgt_cb      (cb_w_reg),
        .wgt_cr      (cr_w_reg),
        .pix         (pix),
        .chroma_blue (result.chroma_blue),
        .chroma_red  (result.chroma_red)
    );

    assign result.valid            = vld_reg[rycc_pkg::PIPE_DEPTH-1];
    assign result.luma_lower_left  = luma[0];
    assign result.luma_lower_right = luma[1];
    assign result.luma_upper_left  = luma[2];
    assign result.luma_upper_right = luma[3];

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.ready |=> vld_reg[0])
        else $error("accepted request did not enter the first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(vld_reg[rycc_pkg::PIPE_DEPTH-2]))
        else $error("result appeared without a request in the last stage");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> pixels.ready)
        else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire
